// ===== hw/rtl/vti_pkg.sv =====
// Shared types and constants of the visibility time integrator.
// No dependencies; used by vti_accum and visibility_time_integrator_core.
package vti_pkg;

  localparam int IDX_W       = 12;
  localparam int VALID_W     = 16;
  localparam int SMP_W       = 32;
  localparam int SUM_W       = 40;
  localparam int NPROD       = 8;
  localparam int CNT_SUM_W   = 24;
  localparam int LEN_W       = 8;
  localparam int SCALE_W     = 32;
  localparam int WEIGHT_W    = 16;
  localparam int PROD_W      = CNT_SUM_W + SCALE_W;
  localparam int ROUND_SHIFT = 17;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 16'd32768;

  localparam int IN_FIELDS_W  = IDX_W + VALID_W + NPROD * SMP_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_PAD_W     = IN_TDATA_W - IN_FIELDS_W;
  localparam int OUT_FIELDS_W = IDX_W + NPROD * SUM_W + WEIGHT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LEN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'd1;

  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    sum_t [NPROD-1:0]     sums;
    logic [CNT_SUM_W-1:0] cnt;
    logic                 flag;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [VALID_W-1:0] valid;
    sum_t [NPROD-1:0]   smp;
    logic               first;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } rslt_t;

endpackage

// ===== hw/rtl/vti_accum.sv =====
// Accumulator memory with read-modify-write pipeline and write forwarding.
// Depends on vti_pkg.
module vti_accum #(
  parameter int ELEMENTS = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vti_pkg::item_t  in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output vti_pkg::rslt_t  out_rslt_o
);

  localparam int IdxSpan = 1 << vti_pkg::IDX_W;
  localparam int Depth   = (ELEMENTS < IdxSpan) ? ELEMENTS : IdxSpan;
  localparam int AddrW   = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic signed [vti_pkg::SUM_W-1:0] SumMax = {1'b0, {(vti_pkg::SUM_W-1){1'b1}}};
  localparam logic signed [vti_pkg::SUM_W-1:0] SumMin = {1'b1, {(vti_pkg::SUM_W-1){1'b0}}};

  vti_pkg::entry_t mem [Depth];

  logic            s1_v_q, s1_v_d;
  vti_pkg::item_t  s1_q;
  vti_pkg::entry_t rd_q;
  logic            s2_v_q, s2_v_d;
  logic            s2_last_q;
  vti_pkg::rslt_t  s2_q;

  logic            s2_adv, s2_free, s1_adv, s1_free, accept, in_range;
  vti_pkg::entry_t old_ent, new_ent;
  logic [vti_pkg::SUM_W:0]     sum_x;
  logic [vti_pkg::CNT_SUM_W:0] cnt_x;

  assign s2_adv     = s2_v_q && (!s2_last_q || out_ready_i);
  assign s2_free    = !s2_v_q || s2_adv;
  assign s1_adv     = s1_v_q && s2_free;
  assign s1_free    = !s1_v_q || s1_adv;
  assign in_ready_o = s1_free;
  assign accept     = in_valid_i && s1_free;
  assign in_range   = 32'(in_item_i.idx) < 32'(ELEMENTS);

  assign s1_v_d = s1_free ? (accept && in_range) : s1_v_q;
  assign s2_v_d = s2_free ? s1_adv : s2_v_q;

  always_comb begin
    old_ent = (s2_v_q && (s2_q.idx == s1_q.idx)) ? s2_q.ent : rd_q;
    new_ent = old_ent;
    sum_x   = '0;
    cnt_x   = '0;
    if (s1_q.first) begin
      new_ent.sums = s1_q.smp;
      new_ent.cnt  = vti_pkg::CNT_SUM_W'(s1_q.valid);
      new_ent.flag = (s1_q.valid == '0);
    end else begin
      for (int k = 0; k < vti_pkg::NPROD; k++) begin
        sum_x = {old_ent.sums[k][vti_pkg::SUM_W-1], old_ent.sums[k]}
              + {s1_q.smp[k][vti_pkg::SUM_W-1], s1_q.smp[k]};
        if (sum_x[vti_pkg::SUM_W] != sum_x[vti_pkg::SUM_W-1]) begin
          new_ent.sums[k] = sum_x[vti_pkg::SUM_W] ? SumMin : SumMax;
        end else begin
          new_ent.sums[k] = sum_x[vti_pkg::SUM_W-1:0];
        end
      end
      cnt_x = {1'b0, old_ent.cnt} + (vti_pkg::CNT_SUM_W + 1)'(s1_q.valid);
      new_ent.cnt  = cnt_x[vti_pkg::CNT_SUM_W] ? '1 : cnt_x[vti_pkg::CNT_SUM_W-1:0];
      new_ent.flag = old_ent.flag && (s1_q.valid == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_item_i;
    end
    if (accept && in_range) begin
      rd_q <= mem[in_item_i.idx[AddrW-1:0]];
    end
    if (s1_adv) begin
      mem[s1_q.idx[AddrW-1:0]] <= new_ent;
      s2_q.idx  <= s1_q.idx;
      s2_q.ent  <= new_ent;
      s2_last_q <= s1_q.last;
    end
  end

  assign out_valid_o = s2_v_q && s2_last_q;
  assign out_rslt_o  = s2_q;

endmodule

// ===== hw/rtl/visibility_time_integrator_core.sv =====
// Windowed accumulate-and-dump integrator for correlator elements.
// Pipeline: a request passes accumulator stages s1 and s2, then the multiply and output registers.
// Throughput: one request per cycle while the master side does not stall, set by the single
// read-modify-write of the accumulator memory per request, with the previous write forwarded.
// Reset clears valid bits, window position and configuration registers; accumulator memory
// keeps its contents and needs no clearing pass.
module visibility_time_integrator_core #(
  parameter int ELEMENTS    = 4096,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [vti_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vti_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // element_index, valid_samples, xx_real, xx_imag, xy_real, xy_imag,
  // yx_real, yx_imag, yy_real, yy_imag, zero pad
  input  logic [vti_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_index, sum_xx_real, sum_xx_imag, sum_xy_real, sum_xy_imag,
  // sum_yx_real, sum_yx_imag, sum_yy_real, sum_yy_imag, weight, zero pad
  output logic [vti_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // all_flagged
  output logic [0:0]                         m_axis_tuser
);

  localparam int SmpBits = (SAMPLE_BITS > vti_pkg::SMP_W) ? vti_pkg::SMP_W : SAMPLE_BITS;
  localparam int ShlAmt  = vti_pkg::SMP_W - SmpBits;
  localparam int ShrAmt  = vti_pkg::SUM_W - SmpBits;
  localparam int SxPad   = vti_pkg::SUM_W - vti_pkg::SMP_W;

  typedef struct packed {
    logic [vti_pkg::IDX_W-1:0]              idx;
    vti_pkg::sum_t [vti_pkg::NPROD-1:0]     sums;
    logic                                   flag;
    logic [vti_pkg::PROD_W-1:0]             prod;
  } mul_t;

  typedef struct packed {
    logic [vti_pkg::IDX_W-1:0]              idx;
    vti_pkg::sum_t [vti_pkg::NPROD-1:0]     sums;
    logic [vti_pkg::WEIGHT_W-1:0]           weight;
    logic                                   flag;
  } out_t;

  logic [vti_pkg::LEN_W-1:0]   len_q;
  logic [vti_pkg::SCALE_W-1:0] scale_q;
  logic [vti_pkg::LEN_W-1:0]   fiw_q, fiw_d;
  logic [vti_pkg::LEN_W-1:0]   len_eff;
  logic                        first, last, accept;
  vti_pkg::item_t              item;

  logic           acc_valid, acc_ready;
  vti_pkg::rslt_t acc_rslt;

  logic  mul_v_q, mul_v_d, mul_adv, mul_free;
  mul_t  mul_q;
  logic  out_v_q, out_v_d, out_free;
  out_t  out_q;

  logic [vti_pkg::PROD_W:0]                   rnd;
  logic [vti_pkg::PROD_W-vti_pkg::ROUND_SHIFT:0] wfull;
  logic [vti_pkg::WEIGHT_W-1:0]               weight;

  // window position
  assign len_eff = (len_q == '0) ? vti_pkg::LEN_W'(1) : len_q;
  assign first   = (fiw_q == '0);
  assign last    = ({1'b0, fiw_q} + (vti_pkg::LEN_W + 1)'(1)) >= {1'b0, len_eff};
  assign accept  = s_axis_tvalid && s_axis_tready;

  always_comb begin
    fiw_d = fiw_q;
    if (accept && s_axis_tlast) begin
      fiw_d = last ? '0 : fiw_q + vti_pkg::LEN_W'(1);
    end
  end

  // unpack and sign-extend samples
  always_comb begin
    item.idx   = s_axis_tdata[vti_pkg::IDX_W-1:0];
    item.valid = s_axis_tdata[vti_pkg::IDX_W +: vti_pkg::VALID_W];
    item.first = first;
    item.last  = last;
    for (int k = 0; k < vti_pkg::NPROD; k++) begin
      item.smp[k] = vti_pkg::sum_t'($signed(
          {s_axis_tdata[vti_pkg::IDX_W + vti_pkg::VALID_W + k * vti_pkg::SMP_W +:
                        vti_pkg::SMP_W], {SxPad{1'b0}}} << ShlAmt) >>> ShrAmt);
    end
  end

  vti_accum #(
    .ELEMENTS(ELEMENTS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (item),
    .out_valid_o (acc_valid),
    .out_ready_i (acc_ready),
    .out_rslt_o  (acc_rslt)
  );

  // weight pipeline
  assign out_free  = !out_v_q || m_axis_tready;
  assign mul_adv   = mul_v_q && out_free;
  assign mul_free  = !mul_v_q || mul_adv;
  assign acc_ready = mul_free;
  assign mul_v_d   = mul_free ? acc_valid : mul_v_q;
  assign out_v_d   = out_free ? mul_v_q : out_v_q;

  assign rnd    = {1'b0, mul_q.prod} + (vti_pkg::PROD_W + 1)'(1 << (vti_pkg::ROUND_SHIFT - 1));
  assign wfull  = rnd[vti_pkg::PROD_W:vti_pkg::ROUND_SHIFT];
  assign weight = (wfull > (vti_pkg::PROD_W - vti_pkg::ROUND_SHIFT + 1)'(vti_pkg::WEIGHT_MAX))
                ? vti_pkg::WEIGHT_MAX : wfull[vti_pkg::WEIGHT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= vti_pkg::LEN_W'(1);
      scale_q <= '0;
      fiw_q   <= '0;
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          vti_pkg::REG_LEN:   len_q   <= cfg_data_i[vti_pkg::LEN_W-1:0];
          vti_pkg::REG_SCALE: scale_q <= cfg_data_i[vti_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      fiw_q   <= fiw_d;
      mul_v_q <= mul_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_valid && acc_ready) begin
      mul_q.idx  <= acc_rslt.idx;
      mul_q.sums <= acc_rslt.ent.sums;
      mul_q.flag <= acc_rslt.ent.flag;
      mul_q.prod <= vti_pkg::PROD_W'(acc_rslt.ent.cnt) * vti_pkg::PROD_W'(scale_q);
    end
    if (mul_adv) begin
      out_q.idx    <= mul_q.idx;
      out_q.sums   <= mul_q.sums;
      out_q.flag   <= mul_q.flag;
      out_q.weight <= weight;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{vti_pkg::OUT_PAD_W{1'b0}}, out_q.weight, out_q.sums, out_q.idx};
  assign m_axis_tuser  = out_q.flag;

endmodule
